// File: rtl/core/phl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phl_pkg
// Shared types and constants for the 128-bit perfect hash lookup pipeline.
// ----------------------------------------------------------------------------
package phl_pkg;

    localparam int MOD_W  = 13;     // modulus / remainder width (up to 8191)
    localparam int HASH_W = 128;
    localparam int WORD_W = 32;

    localparam logic [1:0] CMD_WR_OFFSET = 2'd0;
    localparam logic [1:0] CMD_WR_ENTRY  = 2'd1;
    localparam logic [1:0] CMD_LOOKUP    = 2'd2;
    localparam logic [1:0] CMD_PLACE     = 2'd3;

    localparam logic [1:0] CFG_TABLE_SIZE   = 2'd0;
    localparam logic [1:0] CFG_TABLE_SHIFT  = 2'd1;
    localparam logic [1:0] CFG_OFFSET_SIZE  = 2'd2;
    localparam logic [1:0] CFG_OFFSET_SHIFT = 2'd3;

    // item as it enters the pipe
    typedef struct packed {
        logic [1:0]        cmd;
        logic [11:0]       slot;
        logic [63:0]       hash_low;
        logic [63:0]       hash_high;
        logic [WORD_W-1:0] offset_value;
    } front_t;

    // item after the offset table stage
    typedef struct packed {
        logic [1:0]  cmd;
        logic [11:0] slot;
        logic [63:0] hash_low;
        logic [63:0] hash_high;
    } back_t;

    typedef struct packed {
        back_t rec;
        logic  ovf;
    } tail_t;

endpackage

// File: rtl/core/perfect_hash_lookup_128.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perfect_hash_lookup_128
// Two-level perfect hash store for 128-bit hashes: offset table, entry table,
// lookup with hit/overflow report and placement offset.
// ----------------------------------------------------------------------------
// Takes one command per clock while s_tready is high and returns one result
// per command, in order. The pipe holds the four remainder units (8 + 4
// stages each for the offset and table reductions, eight restoring steps
// per stage), the offset table read, the 128-bit add (low half, then high
// half), two multiply-add stages, the entry table read and the output
// register. Back-pressure on m_tready stalls the whole pipe in place. After
// reset the entry table is swept to zero (TABLE_DEPTH entries, 4096 by
// default); s_tready stays low during the sweep, configuration writes are
// taken at any time. The user must only change configuration while the
// pipe is empty; the block itself does not enforce this. Offset table words
// read by a lookup before they were written return an unspecified value.
// ----------------------------------------------------------------------------
module perfect_hash_lookup_128
    import phl_pkg::*;
#(
    parameter int TABLE_DEPTH  = 4096,
    parameter int OFFSET_DEPTH = 1024
)
(
    input  logic         clk,
    input  logic         rst_n,
    // slave stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // [11:0] slot, [75:12] hash_low, [139:76] hash_high, [171:140] offset_value
    input  logic [175:0] s_tdata,
    // [1:0] cmd
    input  logic [1:0]   s_tuser,
    // master stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // [11:0] table_index, [12] hit, [13] overflow, [26:14] placement_offset
    output logic [31:0]  m_tdata,
    // configuration write channel
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    localparam int OAW = $clog2(OFFSET_DEPTH);
    localparam int TAW = $clog2(TABLE_DEPTH);

    // ---------------- configuration registers ----------------
    logic [12:0] table_size_reg;
    logic [11:0] table_shift_reg;
    logic [10:0] offset_size_reg;
    logic [9:0]  offset_shift_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_size_reg   <= 13'd4096;
            table_shift_reg  <= '0;
            offset_size_reg  <= 11'd1024;
            offset_shift_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_TABLE_SIZE:   table_size_reg   <= cfg_data[12:0];
                CFG_TABLE_SHIFT:  table_shift_reg  <= cfg_data[11:0];
                CFG_OFFSET_SIZE:  offset_size_reg  <= cfg_data[10:0];
                CFG_OFFSET_SHIFT: offset_shift_reg <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // moduli saturated to 1..depth (zero acts as one)
    logic [MOD_W-1:0] tsz;
    logic [MOD_W-1:0] osz;

    always_comb
    begin
        if (table_size_reg == '0)
            tsz = MOD_W'(1);
        else if (32'(table_size_reg) > 32'(TABLE_DEPTH))
            tsz = MOD_W'(TABLE_DEPTH);
        else
            tsz = table_size_reg;

        if (offset_size_reg == '0)
            osz = MOD_W'(1);
        else if (32'(offset_size_reg) > 32'(OFFSET_DEPTH))
            osz = MOD_W'(OFFSET_DEPTH);
        else
            osz = MOD_W'(offset_size_reg);
    end

    // ---------------- pipe control ----------------
    // whole pipe advances while the output register is empty or being drained
    logic   en;
    logic   clr_busy;
    logic   in_fire;
    logic   m_valid_reg;
    front_t in_rec;

    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en && !clr_busy;
    assign in_fire  = s_tvalid && s_tready;

    always_comb
    begin
        in_rec.cmd          = s_tuser;
        in_rec.slot         = s_tdata[11:0];
        in_rec.hash_low     = s_tdata[75:12];
        in_rec.hash_high    = s_tdata[139:76];
        in_rec.offset_value = s_tdata[171:140];
    end

    // ---------------- hash mod offset_size, both halves ----------------
    logic                        a_valid;
    logic [1:0][MOD_W-1:0]       a_rem;
    logic [$bits(front_t)-1:0]   a_tag;

    phl_mod #(
        .IN_W  (64),
        .LANES (2),
        .TAG_W ($bits(front_t))
    ) u_omod_hash (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_fire),
        .in_val    ({in_rec.hash_high, in_rec.hash_low}),
        .in_n      (osz),
        .in_tag    (in_rec),
        .out_valid (a_valid),
        .out_rem   (a_rem),
        .out_tag   (a_tag)
    );

    // (hi mod N) * shift + (lo mod N)
    logic        valid_b_reg;
    front_t      rec_b_reg;
    logic [31:0] mac_b_reg;
    logic [31:0] mac_b_next;

    assign mac_b_next = 32'(a_rem[1]) * 32'(offset_shift_reg) + 32'(a_rem[0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_b_reg <= 1'b0;
        else if (en)
            valid_b_reg <= a_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rec_b_reg <= front_t'(a_tag);
            mac_b_reg <= mac_b_next;
        end
    end

    logic                        c_valid;
    logic [0:0][MOD_W-1:0]       c_rem;
    logic [$bits(front_t)-1:0]   c_tag;
    front_t                      c_rec;

    phl_mod #(
        .IN_W  (32),
        .LANES (1),
        .TAG_W ($bits(front_t))
    ) u_omod_fold (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (valid_b_reg),
        .in_val    (mac_b_reg),
        .in_n      (osz),
        .in_tag    (rec_b_reg),
        .out_valid (c_valid),
        .out_rem   (c_rem),
        .out_tag   (c_tag)
    );

    assign c_rec = front_t'(c_tag);

    // ---------------- offset table ----------------
    logic [WORD_W-1:0] omem [OFFSET_DEPTH];
    logic [WORD_W-1:0] off_rd_reg;
    logic [31:0]       oslot_w;
    logic [31:0]       oidx_w;
    logic              owr;
    logic              valid_d_reg;
    back_t             rec_d_reg;

    assign oslot_w = 32'(c_rec.slot);
    assign oidx_w  = 32'(c_rem[0]);
    assign owr     = en && c_valid && (c_rec.cmd == CMD_WR_OFFSET)
                     && (oslot_w < 32'(OFFSET_DEPTH));

    always_ff @(posedge clk)
    begin
        if (owr)
        begin
            omem[oslot_w[OAW-1:0]] <= c_rec.offset_value;
        end
        if (en)
        begin
            off_rd_reg <= omem[oidx_w[OAW-1:0]];
            rec_d_reg  <= '{cmd: c_rec.cmd, slot: c_rec.slot,
                            hash_low: c_rec.hash_low, hash_high: c_rec.hash_high};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_d_reg <= 1'b0;
        else if (en)
            valid_d_reg <= c_valid;
    end

    // ---------------- 128-bit add, low half then high half ----------------
    logic        valid_e1_reg;
    back_t       rec_e1_reg;
    logic [63:0] slo_e1_reg;
    logic        cy_e1_reg;
    logic [64:0] lo_sum;
    logic [63:0] off_use;

    // placement reduces the plain hash: no offset added
    assign off_use = (rec_d_reg.cmd == CMD_LOOKUP) ? 64'(off_rd_reg) : '0;
    assign lo_sum  = {1'b0, rec_d_reg.hash_low} + {1'b0, off_use};

    logic        valid_e2_reg;
    back_t       rec_e2_reg;
    logic [63:0] slo_e2_reg;
    logic [63:0] shi_e2_reg;
    logic        ovf_e2_reg;
    logic [64:0] hi_sum;

    assign hi_sum = {1'b0, rec_e1_reg.hash_high} + 65'(cy_e1_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_e1_reg <= 1'b0;
            valid_e2_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_e1_reg <= valid_d_reg;
            valid_e2_reg <= valid_e1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rec_e1_reg <= rec_d_reg;
            slo_e1_reg <= lo_sum[63:0];
            cy_e1_reg  <= lo_sum[64];
            rec_e2_reg <= rec_e1_reg;
            slo_e2_reg <= slo_e1_reg;
            shi_e2_reg <= hi_sum[63:0];
            ovf_e2_reg <= hi_sum[64];
        end
    end

    // ---------------- sum mod table_size ----------------
    tail_t                       e2_tail;
    logic                        f_valid;
    logic [1:0][MOD_W-1:0]       f_rem;
    logic [$bits(tail_t)-1:0]    f_tag;

    assign e2_tail = '{rec: rec_e2_reg, ovf: ovf_e2_reg};

    phl_mod #(
        .IN_W  (64),
        .LANES (2),
        .TAG_W ($bits(tail_t))
    ) u_tmod_hash (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (valid_e2_reg),
        .in_val    ({shi_e2_reg, slo_e2_reg}),
        .in_n      (tsz),
        .in_tag    (e2_tail),
        .out_valid (f_valid),
        .out_rem   (f_rem),
        .out_tag   (f_tag)
    );

    logic        valid_g_reg;
    tail_t       tail_g_reg;
    logic [31:0] mac_g_reg;
    logic [31:0] mac_g_next;

    assign mac_g_next = 32'(f_rem[1]) * 32'(table_shift_reg) + 32'(f_rem[0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_g_reg <= 1'b0;
        else if (en)
            valid_g_reg <= f_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tail_g_reg <= tail_t'(f_tag);
            mac_g_reg  <= mac_g_next;
        end
    end

    logic                        h_valid;
    logic [0:0][MOD_W-1:0]       h_rem;
    logic [$bits(tail_t)-1:0]    h_tag;
    tail_t                       h_tail;

    phl_mod #(
        .IN_W  (32),
        .LANES (1),
        .TAG_W ($bits(tail_t))
    ) u_tmod_fold (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (valid_g_reg),
        .in_val    (mac_g_reg),
        .in_n      (tsz),
        .in_tag    (tail_g_reg),
        .out_valid (h_valid),
        .out_rem   (h_rem),
        .out_tag   (h_tag)
    );

    assign h_tail = tail_t'(h_tag);

    // ---------------- entry table ----------------
    logic [31:0]       tslot_w;
    logic [31:0]       tidx_w;
    logic              twr;
    logic [HASH_W-1:0] ent_rd;

    assign tslot_w = 32'(h_tail.rec.slot);
    assign tidx_w  = 32'(h_rem[0]);
    assign twr     = h_valid && (h_tail.rec.cmd == CMD_WR_ENTRY)
                     && (tslot_w < 32'(TABLE_DEPTH));

    phl_entry #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_entry (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .wr_en   (twr),
        .wr_addr (tslot_w[TAW-1:0]),
        .wr_data ({h_tail.rec.hash_high, h_tail.rec.hash_low}),
        .rd_addr (tidx_w[TAW-1:0]),
        .rd_data (ent_rd),
        .busy    (clr_busy)
    );

    logic             valid_i_reg;
    tail_t            tail_i_reg;
    logic [MOD_W-1:0] idx_i_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_i_reg <= 1'b0;
        else if (en)
            valid_i_reg <= h_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tail_i_reg <= h_tail;
            idx_i_reg  <= h_rem[0];
        end
    end

    // ---------------- result ----------------
    logic [11:0] idx_o_next;
    logic        hit_o_next;
    logic        ovf_o_next;
    logic [12:0] place_o_next;
    logic [11:0] idx_o_reg;
    logic        hit_o_reg;
    logic        ovf_o_reg;
    logic [12:0] place_o_reg;

    always_comb
    begin
        idx_o_next   = '0;
        hit_o_next   = 1'b0;
        ovf_o_next   = 1'b0;
        place_o_next = '0;
        case (tail_i_reg.rec.cmd)
            CMD_LOOKUP:
            begin
                if (tail_i_reg.ovf)
                begin
                    ovf_o_next = 1'b1;
                end
                else
                begin
                    idx_o_next = idx_i_reg[11:0];
                    hit_o_next = (ent_rd == {tail_i_reg.rec.hash_high,
                                             tail_i_reg.rec.hash_low});
                end
            end
            CMD_PLACE:
            begin
                place_o_next = 13'(14'(tsz) - 14'(idx_i_reg) + 14'(tail_i_reg.rec.slot));
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (en)
            m_valid_reg <= valid_i_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            idx_o_reg   <= idx_o_next;
            hit_o_reg   <= hit_o_next;
            ovf_o_reg   <= ovf_o_next;
            place_o_reg <= place_o_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, place_o_reg, ovf_o_reg, hit_o_reg, idx_o_reg};

    // ---------------- checks ----------------
    a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy |-> !in_fire)
        else $error("input transfer during entry table sweep");

    a_hit_ovf_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> !(hit_o_reg && ovf_o_reg))
        else $error("hit and overflow both set");

    a_hit_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && hit_o_reg) |-> ({1'b0, idx_o_reg} < tsz))
        else $error("hit index beyond table size");

    a_ovf_only_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_i_reg && tail_i_reg.ovf) |-> (tail_i_reg.rec.cmd == CMD_LOOKUP))
        else $error("carry out on a non-lookup command");

endmodule

// File: rtl/core/phl_mod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phl_mod
// Pipelined remainder unit: eight restoring steps per stage, one tag per item.
// ----------------------------------------------------------------------------
module phl_mod
    import phl_pkg::*;
#(
    parameter int IN_W  = 64,
    parameter int LANES = 1,
    parameter int TAG_W = 1
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic [LANES-1:0][IN_W-1:0]       in_val,
    input  logic [MOD_W-1:0]                 in_n,
    input  logic [TAG_W-1:0]                 in_tag,
    output logic                             out_valid,
    output logic [LANES-1:0][MOD_W-1:0]      out_rem,
    output logic [TAG_W-1:0]                 out_tag
);

    localparam int STEPS  = 8;
    localparam int NSTAGE = IN_W / STEPS;

    function automatic logic [MOD_W-1:0] rem_step(input logic [MOD_W-1:0] r,
                                                  input logic b,
                                                  input logic [MOD_W-1:0] n);
        logic [MOD_W:0] t;
        t = {r, b};
        if (t >= {1'b0, n})
        begin
            t = t - {1'b0, n};
        end
        return t[MOD_W-1:0];
    endfunction

    for (genvar s = 0; s < NSTAGE; s++)
    begin : g_stage
        // per-stage registers
        logic                         valid_reg;
        logic [LANES-1:0][MOD_W-1:0]  rem_reg;
        logic [LANES-1:0][IN_W-1:0]   dvd_reg;
        logic [MOD_W-1:0]             n_reg;
        logic [TAG_W-1:0]             tag_reg;

        logic                         v_in;
        logic [LANES-1:0][MOD_W-1:0]  r_in;
        logic [LANES-1:0][IN_W-1:0]   d_in;
        logic [MOD_W-1:0]             n_in;
        logic [TAG_W-1:0]             t_in;
        logic [LANES-1:0][MOD_W-1:0]  rem_next;
        logic [LANES-1:0][IN_W-1:0]   dvd_next;

        if (s == 0)
        begin : g_first
            assign v_in = in_valid;
            assign r_in = '0;
            assign d_in = in_val;
            assign n_in = in_n;
            assign t_in = in_tag;
        end
        else
        begin : g_rest
            assign v_in = g_stage[s-1].valid_reg;
            assign r_in = g_stage[s-1].rem_reg;
            assign d_in = g_stage[s-1].dvd_reg;
            assign n_in = g_stage[s-1].n_reg;
            assign t_in = g_stage[s-1].tag_reg;
        end

        always_comb
        begin
            logic [MOD_W-1:0] r;
            logic [IN_W-1:0]  d;
            rem_next = '0;
            dvd_next = '0;
            for (int l = 0; l < LANES; l++)
            begin
                r = r_in[l];
                d = d_in[l];
                for (int k = 0; k < STEPS; k++)
                begin
                    r = rem_step(r, d[IN_W-1], n_in);
                    d = {d[IN_W-2:0], 1'b0};
                end
                rem_next[l] = r;
                dvd_next[l] = d;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg <= 1'b0;
            end
            else if (en)
            begin
                valid_reg <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg <= rem_next;
                dvd_reg <= dvd_next;
                n_reg   <= n_in;
                tag_reg <= t_in;
            end
        end
    end

    assign out_valid = g_stage[NSTAGE-1].valid_reg;
    assign out_rem   = g_stage[NSTAGE-1].rem_reg;
    assign out_tag   = g_stage[NSTAGE-1].tag_reg;

endmodule

// File: rtl/core/phl_entry.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phl_entry
// Hash entry store: one write and one registered read per cycle while en is
// high, cleared by a sweep after reset.
// ----------------------------------------------------------------------------
module phl_entry
    import phl_pkg::*;
#(
    parameter int TABLE_DEPTH = 4096
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             wr_en,
    input  logic [$clog2(TABLE_DEPTH)-1:0]   wr_addr,
    input  logic [HASH_W-1:0]                wr_data,
    input  logic [$clog2(TABLE_DEPTH)-1:0]   rd_addr,
    output logic [HASH_W-1:0]                rd_data,
    output logic                             busy
);

    localparam int TAW = $clog2(TABLE_DEPTH);

    logic [HASH_W-1:0] mem [TABLE_DEPTH];
    logic [HASH_W-1:0] rd_reg;
    logic              clr_busy_reg;
    logic [TAW-1:0]    clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_cnt_reg == TAW'(TABLE_DEPTH - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_cnt_reg] <= '0;
        end
        else if (en && wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (en)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_reg;
    assign busy    = clr_busy_reg;

endmodule
